// ----- hdl/afr_pkg.sv -----
// Package for the addressed frame receiver: shared types, codes and the CRC step.
// Used by every module of the block; depends on nothing.
package afr_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'hC0;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_TOP   = 16'h8000;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_A    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_B    = 2'd2;

  // Position of a received byte inside the frame, as tracked by the front end.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_DEST    = 4'd1,
    PH_SRC     = 4'd2,
    PH_CMD     = 4'd3,
    PH_LEN     = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CRC_LO  = 4'd6,
    PH_CRC_HI  = 4'd7,
    PH_END     = 4'd8
  } afr_phase_t;

  // Class of a byte handed to the back end.
  typedef enum logic [2:0] {
    TAG_DEST    = 3'd0,
    TAG_SRC     = 3'd1,
    TAG_CMD     = 3'd2,
    TAG_LEN     = 3'd3,
    TAG_PAYLOAD = 3'd4,
    TAG_CRC_LO  = 3'd5,
    TAG_CRC_HI  = 3'd6,
    TAG_END     = 3'd7
  } afr_tag_t;

  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_BAD_END    = 3'd1,
    V_WRONG_DEST = 3'd2,
    V_BAD_SOURCE = 3'd3,
    V_CRC_BAD    = 3'd4
  } afr_verdict_t;

  typedef struct packed {
    afr_tag_t   tag;
    logic [7:0] data;
  } afr_entry_t;

  // One byte of CRC-16 with polynomial 0x1021, most significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/afr_if.sv -----
// Channel interfaces of the addressed frame receiver: byte input, result output
// and configuration writes. Depends on afr_pkg for the index width.
interface afr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afr_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic [7:0] dest_field;
  logic [7:0] source_field;
  logic [7:0] command_code;
  logic [7:0] payload_count;
  modport source (output valid, output verdict, output dest_field, output source_field,
                  output command_code, output payload_count, input ready);
  modport sink (input valid, input verdict, input dest_field, input source_field,
                input command_code, input payload_count, output ready);
endinterface

interface afr_cfg_if
  import afr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/afr_front.sv -----
// Front end: accepts link bytes, tracks the frame position and tags each byte.
// Depends on afr_pkg and afr_if.
module afr_front
  import afr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  afr_byte_if.sink    rx,
  output logic        q_valid,
  output afr_entry_t  q_entry,
  input  logic        q_ready
);

  afr_phase_t phase, phase_next;
  logic [7:0] payload_left, payload_left_next;
  logic       accept;

  // Bytes while idle never enter the queue, so they are taken regardless of it.
  assign rx.ready = q_ready || (phase == PH_IDLE);
  assign accept   = rx.valid && rx.ready;
  assign q_valid  = rx.valid && (phase != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      payload_left <= 8'd0;
    end else begin
      phase        <= phase_next;
      payload_left <= payload_left_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    payload_left_next = payload_left;
    q_entry.data      = rx.rx_byte;
    q_entry.tag       = TAG_END;
    unique case (phase)
      PH_IDLE: begin
        if (accept && rx.rx_byte == FLAG_BYTE) begin
          phase_next = PH_DEST;
        end
      end
      PH_DEST: begin
        q_entry.tag = TAG_DEST;
        if (accept) phase_next = PH_SRC;
      end
      PH_SRC: begin
        q_entry.tag = TAG_SRC;
        if (accept) phase_next = PH_CMD;
      end
      PH_CMD: begin
        q_entry.tag = TAG_CMD;
        if (accept) phase_next = PH_LEN;
      end
      PH_LEN: begin
        q_entry.tag = TAG_LEN;
        if (accept) begin
          payload_left_next = rx.rx_byte;
          phase_next = (rx.rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        q_entry.tag = TAG_PAYLOAD;
        if (accept) begin
          payload_left_next = payload_left - 8'd1;
          if (payload_left == 8'd1) phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        q_entry.tag = TAG_CRC_LO;
        if (accept) phase_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        q_entry.tag = TAG_CRC_HI;
        if (accept) phase_next = PH_END;
      end
      PH_END: begin
        q_entry.tag = TAG_END;
        if (accept) phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/afr_queue.sv -----
// Two-entry queue of tagged bytes between the front end and the back end.
// Depends on afr_pkg for the entry type.
module afr_queue
  import afr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  afr_entry_t in_entry,
  output logic       in_ready,
  output logic       out_valid,
  output afr_entry_t out_entry,
  input  logic       out_ready
);

  afr_entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_entry = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_entry;
  end

endmodule

// ----- hdl/afr_back.sv -----
// Back end: runs the CRC, holds the header fields and issues the verdict.
// Depends on afr_pkg and afr_if.
module afr_back
  import afr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  afr_entry_t  q_entry,
  output logic        q_ready,
  afr_cfg_if.sink     cfg,
  afr_result_if.source res
);

  logic [7:0]   own_address, allowed_source_a, allowed_source_b;
  logic [7:0]   held_dest, held_source, held_command, payload_length;
  logic [15:0]  running_crc, received_crc;
  logic         out_free, pop;
  afr_verdict_t verdict_next;

  assign cfg.ready = 1'b1;
  assign out_free  = !res.valid || res.ready;
  assign q_ready   = (q_entry.tag != TAG_END) || out_free;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address      <= 8'd0;
      allowed_source_a <= 8'd0;
      allowed_source_b <= 8'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_OWN_ADDRESS: own_address      <= cfg.data;
        CFG_SOURCE_A:    allowed_source_a <= cfg.data;
        CFG_SOURCE_B:    allowed_source_b <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (q_entry.data != FLAG_BYTE) begin
      verdict_next = V_BAD_END;
    end else if (held_dest != own_address) begin
      verdict_next = V_WRONG_DEST;
    end else if (held_source != allowed_source_a && held_source != allowed_source_b) begin
      verdict_next = V_BAD_SOURCE;
    end else if (running_crc != received_crc) begin
      verdict_next = V_CRC_BAD;
    end else begin
      verdict_next = V_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= CRC_INIT;
      received_crc   <= 16'h0000;
      held_dest      <= 8'd0;
      held_source    <= 8'd0;
      held_command   <= 8'd0;
      payload_length <= 8'd0;
    end else if (pop) begin
      unique case (q_entry.tag)
        TAG_DEST: begin
          held_dest   <= q_entry.data;
          running_crc <= crc_feed(CRC_INIT, q_entry.data);
        end
        TAG_SRC: begin
          held_source <= q_entry.data;
          running_crc <= crc_feed(running_crc, q_entry.data);
        end
        TAG_CMD: begin
          held_command <= q_entry.data;
          running_crc  <= crc_feed(running_crc, q_entry.data);
        end
        TAG_LEN: begin
          payload_length <= q_entry.data;
          running_crc    <= crc_feed(running_crc, q_entry.data);
        end
        TAG_PAYLOAD: running_crc <= crc_feed(running_crc, q_entry.data);
        TAG_CRC_LO:  received_crc <= {8'h00, q_entry.data};
        TAG_CRC_HI:  received_crc <= {q_entry.data, received_crc[7:0]};
        TAG_END: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop && q_entry.tag == TAG_END) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.tag == TAG_END) begin
      res.verdict       <= verdict_next;
      res.dest_field    <= held_dest;
      res.source_field  <= held_source;
      res.command_code  <= held_command;
      res.payload_count <= payload_length;
    end
  end

endmodule

// ----- hdl/addressed_frame_receiver_crc16.sv -----
// Top level of the addressed frame receiver with CRC-16 check.
// Depends on afr_pkg, afr_if, afr_front, afr_queue and afr_back.
//
//   channel  direction  carries                                   accepted when
//   rx       in         rx_byte                                   rx.valid & rx.ready
//   res      out        verdict, dest/source fields, command,     res.valid & res.ready
//                       payload count
//   cfg      in         register index and data                   cfg.valid & cfg.ready
//
// One byte can be accepted every clock cycle while the queue has room. The front end
// is combinational, so a byte enters the queue at the edge that accepts it and, unless
// the result output stalls, reaches the back end in the next cycle; the verdict is
// registered at the edge where the end byte leaves the queue.
// The queue holds two tagged bytes, so a stalled result output only holds off
// the input once the queue is full; bytes seen while idle are always taken.
// Reset is synchronous and active high; it clears all registers bar queue slots and
// result fields to zero and the CRC to its initial value, and needs no clearing pass.
module addressed_frame_receiver_crc16
  import afr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  afr_byte_if.sink     rx,
  afr_result_if.source res,
  afr_cfg_if.sink      cfg
);

  // Tagged bytes from the front end into the queue.
  logic       front_valid, front_ready;
  afr_entry_t front_entry;

  // Tagged bytes from the queue into the back end.
  logic       back_valid, back_ready;
  afr_entry_t back_entry;

  // The front end follows the frame layout, which depends only on the bytes
  // themselves, and tags each byte with its position in the frame.
  afr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_valid (front_valid),
    .q_entry (front_entry),
    .q_ready (front_ready)
  );

  afr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_entry  (front_entry),
    .in_ready  (front_ready),
    .out_valid (back_valid),
    .out_entry (back_entry),
    .out_ready (back_ready)
  );

  // The back end owns the configuration registers, the running CRC and the
  // held header fields, and produces the verdict at the end byte.
  afr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (back_valid),
    .q_entry (back_entry),
    .q_ready (back_ready),
    .cfg     (cfg),
    .res     (res)
  );

endmodule

// ----- sim/addressed_frame_receiver_crc16_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for addressed_frame_receiver_crc16: it drives frames through the
// byte and register channels and checks every verdict against a predictor kept in a class.
// Depends on afr_pkg, the afr_if channel interfaces and the receiver's RTL.
module addressed_frame_receiver_crc16_tb;
  import afr_pkg::*;

  // The register channel has a two-bit index, so index three exists but names no register.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int STALL_PERCENT  = 36;
  // Once no verdict is awaited, the queue holds at most two non-end bytes, which the back
  // end always takes without stalling, so this drain is ample.
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  // Frame bytes per random phase; four phases plus the longest frame make about 1100 items.
  localparam int PHASE_BUDGET   = 190;

  typedef struct {
    afr_verdict_t verdict;
    logic [7:0]   dest;
    logic [7:0]   source;
    logic [7:0]   command;
    logic [7:0]   count;
  } frame_verdict_t;

  // Tracks the receiver's frame position and CRC, and holds the verdicts still to come.
  class frame_verdict_board;
    logic [7:0]     own_address;
    logic [7:0]     source_a;
    logic [7:0]     source_b;
    afr_phase_t     phase;
    logic [7:0]     bytes_left;
    logic [7:0]     pay_len;
    logic [7:0]     dest;
    logic [7:0]     source;
    logic [7:0]     command;
    logic [15:0]    crc;
    logic [15:0]    frame_crc;
    frame_verdict_t awaited[$];
    int             failures;
    int             tally[5];

    function new();
      own_address = 8'h00;
      source_a    = 8'h00;
      source_b    = 8'h00;
      phase       = PH_IDLE;
      bytes_left  = 8'h00;
      pay_len     = 8'h00;
      dest        = 8'h00;
      source      = 8'h00;
      command     = 8'h00;
      crc         = CRC_INIT;
      frame_crc   = 16'h0000;
      failures    = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    // CRC-16 with polynomial 0x1021, one message bit at a time, most significant first.
    static function logic [15:0] crc_step(logic [15:0] crc_in, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      int          i;
      r = crc_in;
      for (i = 7; i >= 0; i--) begin
        fb = r[15] ^ b[i];
        r  = {r[14:0], 1'b0};
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
      return r;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [7:0] data);
      case (index)
        CFG_OWN_ADDRESS: own_address = data;
        CFG_SOURCE_A:    source_a = data;
        CFG_SOURCE_B:    source_b = data;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      frame_verdict_t v;
      case (phase)
        PH_DEST: begin
          dest  = b;
          crc   = crc_step(crc, b);
          phase = PH_SRC;
        end
        PH_SRC: begin
          source = b;
          crc    = crc_step(crc, b);
          phase  = PH_CMD;
        end
        PH_CMD: begin
          command = b;
          crc     = crc_step(crc, b);
          phase   = PH_LEN;
        end
        PH_LEN: begin
          pay_len    = b;
          bytes_left = b;
          crc        = crc_step(crc, b);
          phase      = (b == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc        = crc_step(crc, b);
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'h00) begin
            phase = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          frame_crc = {8'h00, b};
          phase     = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          frame_crc[15:8] = b;
          phase           = PH_END;
        end
        PH_END: begin
          if (b != FLAG_BYTE) begin
            v.verdict = V_BAD_END;
          end else if (dest != own_address) begin
            v.verdict = V_WRONG_DEST;
          end else if (source != source_a && source != source_b) begin
            v.verdict = V_BAD_SOURCE;
          end else if (crc != frame_crc) begin
            v.verdict = V_CRC_BAD;
          end else begin
            v.verdict = V_OK;
          end
          v.dest    = dest;
          v.source  = source;
          v.command = command;
          v.count   = pay_len;
          awaited.push_back(v);
          phase = PH_IDLE;
        end
        default: begin
          if (b == FLAG_BYTE) begin
            crc        = CRC_INIT;
            frame_crc  = 16'h0000;
            bytes_left = 8'h00;
            phase      = PH_DEST;
          end else begin
            phase = PH_IDLE;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_verdict(logic [2:0] verdict, logic [7:0] d, logic [7:0] s,
                                logic [7:0] c, logic [7:0] n);
      frame_verdict_t want;
      if (awaited.size() == 0) begin
        $error("verdict %0d for dest %0d source %0d arrived with no frame awaiting it",
               verdict, d, s);
        failures++;
        return;
      end
      want = awaited.pop_front();
      compare_field("verdict", {5'b00000, want.verdict}, {5'b00000, verdict});
      compare_field("dest_field", want.dest, d);
      compare_field("source_field", want.source, s);
      compare_field("command_code", want.command, c);
      compare_field("payload_count", want.count, n);
      tally[int'(want.verdict)]++;
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic throttle;
  int   bytes_accepted;
  int   frame_bytes;

  afr_byte_if   rx_if();
  afr_result_if res_if();
  afr_cfg_if    cfg_if();

  frame_verdict_board board = new();

  addressed_frame_receiver_crc16 dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Every handshake is sampled at the rising edge, where all inputs have been stable since
  // the falling edge. Register writes, bytes and verdicts are handled in one place so that
  // the predictor always sees them in a fixed order.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        board.set_register(cfg_if.index, cfg_if.data);
      end
      if (rx_if.valid && rx_if.ready) begin
        board.note_byte(rx_if.rx_byte);
        bytes_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        board.check_verdict(res_if.verdict, res_if.dest_field, res_if.source_field,
                            res_if.command_code, res_if.payload_count);
      end
    end
  end

  // The watchdog counts cycles in which no channel moves anything. A correct run never comes
  // near the limit: the longest pauses are the short drains between phases.
  always @(posedge clk) begin
    int quiet;
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $error("no handshake for %0d cycles, %0d verdicts still awaited", quiet,
               board.pending());
        $display("** addressed_frame_receiver_crc16: FAILED **");
        $finish;
      end
    end
  end

  // Back-pressure on the result channel. With throttling off the ready stays high, which
  // gives the long stretch in which the receiver runs at full rate.
  always @(negedge clk) begin
    res_if.ready <= throttle ? ($urandom_range(0, 99) >= STALL_PERCENT) : 1'b1;
  end

  // Offers one byte, possibly after idle cycles while throttling is on, and returns on the edge that takes it.
  // The valid is left high so that the next byte can follow in the very next cycle.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (throttle && $urandom_range(0, 99) < STALL_PERCENT) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stops offering bytes and waits until every awaited verdict has come back. A frame may
  // still be part-way through the queue even then, so the drain runs before the
  // registers may be touched.
  task automatic settle();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Builds a frame with a random payload and sends it. The CRC is computed here and then
  // XORed with crc_flip, so a non-zero flip makes a CRC mismatch. A non-zero cut sends only
  // that many leading bytes, leaving the receiver to swallow what follows as frame content.
  task automatic send_frame(input logic [7:0] dest, input logic [7:0] source,
                            input logic [7:0] command, input logic [7:0] pay_len,
                            input logic [15:0] crc_flip, input logic [7:0] end_byte,
                            input int cut);
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          i;
    int          sent;
    frame.push_back(FLAG_BYTE);
    frame.push_back(dest);
    frame.push_back(source);
    frame.push_back(command);
    frame.push_back(pay_len);
    for (i = 0; i < int'(pay_len); i++) begin
      // A flag byte inside a frame is plain data, so it turns up in payloads now and then.
      b = ($urandom_range(0, 9) == 0) ? FLAG_BYTE : 8'($urandom_range(0, 255));
      frame.push_back(b);
    end
    crc = CRC_INIT;
    for (i = 1; i < frame.size(); i++) begin
      crc = frame_verdict_board::crc_step(crc, frame[i]);
    end
    crc = crc ^ crc_flip;
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    frame.push_back(end_byte);
    sent = (cut > 0 && cut < frame.size()) ? cut : frame.size();
    for (i = 0; i < sent; i++) begin
      send_byte(frame[i]);
    end
    frame_bytes += sent;
  endtask

  // Mostly well-formed frames addressed to this receiver from an allowed sender, so that
  // the CRC and the ok verdict are reached often; the rest misaddressed, from strangers,
  // corrupted, badly terminated or cut short, with stray bytes in between now and then.
  task automatic random_frame();
    logic [7:0]  dest;
    logic [7:0]  source;
    logic [7:0]  pay_len;
    logic [7:0]  end_byte;
    logic [15:0] flip;
    int          pick;
    int          cut;
    dest = ($urandom_range(0, 99) < 75) ? board.own_address : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      source = board.source_a;
    end else if (pick < 80) begin
      source = board.source_b;
    end else begin
      source = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 88) begin
      pay_len = 8'($urandom_range(0, 8));
    end else if (pick < 99) begin
      pay_len = 8'($urandom_range(9, 40));
    end else begin
      pay_len = 8'($urandom_range(41, 255));
    end
    flip     = ($urandom_range(0, 99) < 12) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    end_byte = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(0, 255)) : FLAG_BYTE;
    cut      = ($urandom_range(0, 99) < 5) ? $urandom_range(1, 6) : 0;
    send_frame(dest, source, 8'($urandom_range(0, 255)), pay_len, flip, end_byte, cut);
    if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input int budget);
    int start;
    start = frame_bytes;
    while (frame_bytes - start < budget) begin
      random_frame();
    end
    settle();
  endtask

  initial begin
    rst            = 1'b1;
    throttle       = 1'b1;
    bytes_accepted = 0;
    frame_bytes    = 0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = 8'h00;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_OWN_ADDRESS;
    cfg_if.data    = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The own address is the flag value itself, so the destination and
    // command bytes below show that a flag inside a frame is taken as ordinary data.
    cfg_write(CFG_OWN_ADDRESS, FLAG_BYTE);
    cfg_write(CFG_SOURCE_A, 8'h3C);
    cfg_write(CFG_SOURCE_B, 8'hA5);
    // Bytes other than the start flag are ignored while idle.
    send_byte(8'h00);
    send_byte(8'hFF);
    // A clean frame with no payload: the CRC follows the length byte directly.
    send_frame(FLAG_BYTE, 8'h3C, FLAG_BYTE, 8'h00, 16'h0000, FLAG_BYTE, 0);
    // A bad end flag wins over everything else and is not taken as a new start.
    send_frame(FLAG_BYTE, 8'hA5, 8'hFF, 8'h00, 16'h0000, 8'hFF, 0);
    // One payload byte and a corrupted CRC.
    send_frame(FLAG_BYTE, 8'h3C, 8'h00, 8'h01, 16'h8001, FLAG_BYTE, 0);
    settle();

    // Lowest own address, and the two allowed senders at opposite extremes.
    cfg_write(CFG_OWN_ADDRESS, 8'h00);
    cfg_write(CFG_SOURCE_A, 8'h00);
    cfg_write(CFG_SOURCE_B, 8'hFF);
    run_phase(PHASE_BUDGET);

    // Highest own address, with one frame of the longest payload the length byte allows.
    cfg_write(CFG_OWN_ADDRESS, 8'hFF);
    cfg_write(CFG_SOURCE_A, 8'hFF);
    cfg_write(CFG_SOURCE_B, 8'h00);
    send_frame(8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'hFF, 16'h0000, FLAG_BYTE, 0);
    run_phase(PHASE_BUDGET);

    // Random settings, plus a write to the unused index, which must change nothing.
    cfg_write(CFG_OWN_ADDRESS, 8'($urandom_range(0, 255)));
    cfg_write(CFG_SOURCE_A, 8'($urandom_range(0, 255)));
    cfg_write(CFG_SOURCE_B, 8'($urandom_range(0, 255)));
    cfg_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
    run_phase(PHASE_BUDGET);

    // Full rate on both sides for a whole phase.
    throttle = 1'b0;
    cfg_write(CFG_OWN_ADDRESS, 8'($urandom_range(0, 255)));
    cfg_write(CFG_SOURCE_A, 8'($urandom_range(0, 255)));
    cfg_write(CFG_SOURCE_B, 8'($urandom_range(0, 255)));
    run_phase(PHASE_BUDGET);

    $display("%0d bytes taken over five register settings, with and without stalls.",
             bytes_accepted);
    $display("Verdicts checked: %0d ok, %0d bad end flag, %0d wrong destination, %0d %s",
             board.tally[V_OK], board.tally[V_BAD_END], board.tally[V_WRONG_DEST],
             board.tally[V_BAD_SOURCE], "unauthorised source,");
    $display("  and %0d CRC mismatch.", board.tally[V_CRC_BAD]);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("** addressed_frame_receiver_crc16: PASSED **");
    end else begin
      $display("** addressed_frame_receiver_crc16: FAILED **");
    end
    $finish;
  end

endmodule
